// ----- hw/rtl/trlp_pkg.sv -----
`timescale 1ns / 1ps

package trlp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int IDXW = 5;
    localparam int XW = 36;
    localparam int ZW = 34;

    // Inverse CORDIC gain in Q6.30, used as the start vector of the rotation.
    localparam logic signed [XW-1:0] GAIN_INV = 36'sd652032874;

    typedef enum logic [1:0] {
        REG_TURN_RATE  = 2'd0,
        REG_MOVE_SPEED = 2'd1,
        REG_NEAR_LIMIT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        head;
        logic               steer;
        logic [19:0]        maxt;
        logic [31:0]        len;
        logic               flip;
    } side_t;

    typedef struct packed {
        logic                 vld;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        side_t                side;
    } stage_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic [15:0]        new_heading;
        logic               steered;
    } result_t;

    function automatic logic [31:0] atan_val(input logic [IDXW-1:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:    r = 32'h20000000;
                5'd1:    r = 32'h12E4051E;
                5'd2:    r = 32'h09FB385B;
                5'd3:    r = 32'h051111D4;
                5'd4:    r = 32'h028B0D43;
                5'd5:    r = 32'h0145D7E1;
                5'd6:    r = 32'h00A2F61E;
                5'd7:    r = 32'h00517C55;
                5'd8:    r = 32'h0028BE53;
                5'd9:    r = 32'h00145F2F;
                5'd10:   r = 32'h000A2F98;
                5'd11:   r = 32'h000517CC;
                5'd12:   r = 32'h00028BE6;
                5'd13:   r = 32'h000145F3;
                5'd14:   r = 32'h0000A2FA;
                5'd15:   r = 32'h0000517D;
                5'd16:   r = 32'h000028BE;
                5'd17:   r = 32'h0000145F;
                5'd18:   r = 32'h00000A30;
                5'd19:   r = 32'h00000518;
                5'd20:   r = 32'h0000028C;
                5'd21:   r = 32'h00000146;
                5'd22:   r = 32'h000000A3;
                5'd23:   r = 32'h00000051;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/trlp_if.sv -----
`timescale 1ns / 1ps

interface trlp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic               target_valid;
    logic [15:0]        step_time;

    modport source (output valid, pos_x, pos_y, heading, target_x, target_y,
                    target_valid, step_time, input ready);
    modport sink (input valid, pos_x, pos_y, heading, target_x, target_y,
                  target_valid, step_time, output ready);
endinterface

interface trlp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [15:0]        new_heading;
    logic               steered;

    modport source (output valid, new_x, new_y, new_heading, steered, input ready);
    modport sink (input valid, new_x, new_y, new_heading, steered, output ready);
endinterface

// ----- hw/rtl/turn_rate_limited_pursuit.sv -----
`timescale 1ns / 1ps

// Turn-rate-limited pursuit steering for one mover per request.
// Input channel: mover position and heading, target position with a valid
// flag, and the tick length. Output channel: new position, new heading and a
// flag that tells whether the heading was steered toward the target.
// Configuration (turn_rate, move_speed, near_limit) is written through
// cfg_we / cfg_index / cfg_data. The user must write it only while no
// request is in flight; the block itself does not enforce this.
// The request passes through 38 register stages: two setup stages, one
// CORDIC vectoring cell per step (16), one steering stage, one CORDIC
// rotation cell per step (16), two multiply stages and the output register.
// One request is accepted every cycle while the pipeline does not hold; the
// cell chains set that rate, each cell doing one CORDIC step per cycle.
// Reset clears every valid bit and loads the register defaults; no pass
// over any memory is needed. When the receiver stalls, the output register
// holds its request and a skid register catches the next one; only then does
// the whole pipeline hold and input ready drop, and it rises again in the
// cycle after the output is taken.

module turn_rate_limited_pursuit
(
    input  logic        clk,
    input  logic        rst_n,
    trlp_in_if.sink     in,
    trlp_out_if.source  out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [19:0]      turn_rate_reg;
    logic [31:0]      move_speed_reg;
    logic [31:0]      near_limit_reg;
    logic             adv;

    trlp_pkg::stage_t vec_s [0:trlp_pkg::CORDIC_STEPS];
    trlp_pkg::stage_t rot_s [0:trlp_pkg::CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_rate_reg  <= 20'd31291;
            move_speed_reg <= 32'd0;
            near_limit_reg <= 32'd32768;
        end
        else if (cfg_we)
        begin
            unique case (trlp_pkg::cfg_reg_t'(cfg_index))
                trlp_pkg::REG_TURN_RATE:  turn_rate_reg  <= cfg_data[19:0];
                trlp_pkg::REG_MOVE_SPEED: move_speed_reg <= cfg_data;
                trlp_pkg::REG_NEAR_LIMIT: near_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    trlp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in         (in),
        .turn_rate  (turn_rate_reg),
        .move_speed (move_speed_reg),
        .near_limit (near_limit_reg),
        .q          (vec_s[0])
    );

    for (genvar g = 0; g < trlp_pkg::CORDIC_STEPS; g++)
    begin : g_vec
        trlp_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .vec_mode (1'b1),
            .idx      (trlp_pkg::IDXW'(g)),
            .d        (vec_s[g]),
            .q        (vec_s[g+1])
        );
    end

    trlp_steer u_steer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .d     (vec_s[trlp_pkg::CORDIC_STEPS]),
        .q     (rot_s[0])
    );

    for (genvar g = 0; g < trlp_pkg::CORDIC_STEPS; g++)
    begin : g_rot
        trlp_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .vec_mode (1'b0),
            .idx      (trlp_pkg::IDXW'(g)),
            .d        (rot_s[g]),
            .q        (rot_s[g+1])
        );
    end

    trlp_move u_move
    (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (rot_s[trlp_pkg::CORDIC_STEPS]),
        .out   (out),
        .adv   (adv)
    );

endmodule

// ----- hw/rtl/trlp_cell.sv -----
`timescale 1ns / 1ps

module trlp_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          vec_mode,
    input  logic [trlp_pkg::IDXW-1:0]     idx,
    input  trlp_pkg::stage_t              d,
    output trlp_pkg::stage_t              q
);

    logic signed [trlp_pkg::XW-1:0] xs;
    logic signed [trlp_pkg::XW-1:0] ys;
    logic signed [trlp_pkg::ZW-1:0] a_ext;
    logic                           cw;
    trlp_pkg::stage_t               q_reg;
    trlp_pkg::stage_t               q_next;

    assign xs = d.x >>> idx;
    assign ys = d.y >>> idx;
    assign a_ext = $signed({{(trlp_pkg::ZW-32){1'b0}}, trlp_pkg::atan_val(idx)});

    // Vectoring drives y toward zero, rotation drives the residual angle to zero.
    assign cw = vec_mode ? (d.y > 0) : d.z[trlp_pkg::ZW-1];

    always_comb
    begin
        q_next = d;
        if (cw)
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + a_ext;
        end
        else
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - a_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg.vld <= 1'b0;
        end
        else if (adv)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ----- hw/rtl/trlp_front.sv -----
`timescale 1ns / 1ps

module trlp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    trlp_in_if.sink           in,
    input  logic [19:0]       turn_rate,
    input  logic [31:0]       move_speed,
    input  logic [31:0]       near_limit,
    output trlp_pkg::stage_t  q
);

    logic                           s0_vld_reg;
    logic signed [32:0]             dx_reg;
    logic signed [32:0]             dy_reg;
    logic signed [31:0]             s0_px_reg;
    logic signed [31:0]             s0_py_reg;
    logic [15:0]                    s0_head_reg;
    logic                           s0_tv_reg;
    logic [15:0]                    s0_dt_reg;

    logic                           s1_vld_reg;
    logic [63:0]                    sqx_reg;
    logic [63:0]                    sqy_reg;
    logic [63:0]                    lim_reg;
    logic [35:0]                    tprod_reg;
    logic [47:0]                    mprod_reg;
    logic signed [trlp_pkg::XW-1:0] x0_reg;
    logic signed [trlp_pkg::XW-1:0] y0_reg;
    logic signed [trlp_pkg::ZW-1:0] z0_reg;
    logic signed [31:0]             s1_px_reg;
    logic signed [31:0]             s1_py_reg;
    logic [15:0]                    s1_head_reg;
    logic                           s1_tv_reg;

    logic signed [32:0]             ndx;
    logic signed [32:0]             ndy;
    logic [31:0]                    ax;
    logic [31:0]                    ay;
    logic signed [trlp_pkg::XW-1:0] dxe;
    logic signed [trlp_pkg::XW-1:0] dye;
    logic [64:0]                    dist_sum;
    logic                           far;
    logic [36:0]                    tround;
    logic [47:0]                    mround;

    assign in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg  <= in.valid;
            dx_reg      <= {in.target_x[31], in.target_x} - {in.pos_x[31], in.pos_x};
            dy_reg      <= {in.target_y[31], in.target_y} - {in.pos_y[31], in.pos_y};
            s0_px_reg   <= in.pos_x;
            s0_py_reg   <= in.pos_y;
            s0_head_reg <= in.heading;
            s0_tv_reg   <= in.target_valid;
            s0_dt_reg   <= in.step_time;

            s1_vld_reg  <= s0_vld_reg;
            sqx_reg     <= {32'd0, ax} * {32'd0, ax};
            sqy_reg     <= {32'd0, ay} * {32'd0, ay};
            lim_reg     <= {32'd0, near_limit} * {32'd0, near_limit};
            tprod_reg   <= {16'd0, turn_rate} * {20'd0, s0_dt_reg};
            mprod_reg   <= {16'd0, move_speed} * {32'd0, s0_dt_reg};
            x0_reg      <= dx_reg[32] ? -dxe : dxe;
            y0_reg      <= dx_reg[32] ? -dye : dye;
            z0_reg      <= dx_reg[32] ? {2'b00, 32'h80000000} : '0;
            s1_px_reg   <= s0_px_reg;
            s1_py_reg   <= s0_py_reg;
            s1_head_reg <= s0_head_reg;
            s1_tv_reg   <= s0_tv_reg;
        end
    end

    assign ndx = -dx_reg;
    assign ndy = -dy_reg;
    assign ax = dx_reg[32] ? ndx[31:0] : dx_reg[31:0];
    assign ay = dy_reg[32] ? ndy[31:0] : dy_reg[31:0];
    assign dxe = {{(trlp_pkg::XW-33){dx_reg[32]}}, dx_reg};
    assign dye = {{(trlp_pkg::XW-33){dy_reg[32]}}, dy_reg};

    // The squared distance is kept at full width, so no overflow case remains.
    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign far = s1_tv_reg && (dist_sum > {1'b0, lim_reg});
    assign tround = {1'b0, tprod_reg} + 37'h8000;
    assign mround = mprod_reg + 48'h8000;

    always_comb
    begin
        q            = '0;
        q.vld        = s1_vld_reg;
        q.x          = x0_reg;
        q.y          = y0_reg;
        q.z          = z0_reg;
        q.side.px    = s1_px_reg;
        q.side.py    = s1_py_reg;
        q.side.head  = s1_head_reg;
        q.side.steer = far;
        q.side.maxt  = tround[35:16];
        q.side.len   = mround[47:16];
        q.side.flip  = 1'b0;
    end

endmodule

// ----- hw/rtl/trlp_steer.sv -----
`timescale 1ns / 1ps

module trlp_steer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  trlp_pkg::stage_t  d,
    output trlp_pkg::stage_t  q
);

    logic                vld_reg;
    logic [15:0]         head_reg;
    logic                steer_reg;
    logic signed [31:0]  px_reg;
    logic signed [31:0]  py_reg;
    logic [31:0]         len_reg;

    logic [31:0]         bear_r;
    logic [15:0]         err;
    logic signed [20:0]  err_e;
    logic signed [20:0]  mt;
    logic signed [20:0]  turn;
    logic [15:0]         head_next;
    logic                flip;
    logic [15:0]         af;

    assign bear_r = d.z[31:0] + 32'h8000;
    assign err = bear_r[31:16] - d.side.head;
    assign err_e = {{5{err[15]}}, err};
    assign mt = {1'b0, d.side.maxt};

    always_comb
    begin
        if (err_e > 0)
        begin
            turn = (err_e < mt) ? err_e : mt;
        end
        else
        begin
            turn = (err_e > -mt) ? err_e : -mt;
        end
        head_next = d.side.steer ? (d.side.head + turn[15:0]) : d.side.head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg   <= d.vld;
            head_reg  <= head_next;
            steer_reg <= d.side.steer;
            px_reg    <= d.side.px;
            py_reg    <= d.side.py;
            len_reg   <= d.side.len;
        end
    end

    // Angles in the left half plane are folded by a half turn and the result negated.
    assign flip = head_reg[15] ^ head_reg[14];
    assign af = flip ? (head_reg ^ 16'h8000) : head_reg;

    always_comb
    begin
        q            = '0;
        q.vld        = vld_reg;
        q.x          = trlp_pkg::GAIN_INV;
        q.y          = '0;
        q.z          = {{(trlp_pkg::ZW-32){af[15]}}, af, 16'd0};
        q.side.px    = px_reg;
        q.side.py    = py_reg;
        q.side.head  = head_reg;
        q.side.steer = steer_reg;
        q.side.len   = len_reg;
        q.side.flip  = flip;
    end

endmodule

// ----- hw/rtl/trlp_move.sv -----
`timescale 1ns / 1ps

module trlp_move
(
    input  logic              clk,
    input  logic              rst_n,
    input  trlp_pkg::stage_t  d,
    trlp_out_if.source        out,
    output logic              adv
);

    logic                           m1_vld_reg;
    logic signed [31:0]             c_reg;
    logic signed [31:0]             s_reg;
    logic signed [31:0]             m1_px_reg;
    logic signed [31:0]             m1_py_reg;
    logic [15:0]                    m1_head_reg;
    logic                           m1_steer_reg;
    logic [31:0]                    m1_len_reg;

    logic                           m2_vld_reg;
    logic signed [64:0]             prod_x_reg;
    logic signed [64:0]             prod_y_reg;
    logic signed [31:0]             m2_px_reg;
    logic signed [31:0]             m2_py_reg;
    logic [15:0]                    m2_head_reg;
    logic                           m2_steer_reg;

    logic                           out_vld_reg;
    logic                           skid_full_reg;
    trlp_pkg::result_t              out_reg;
    trlp_pkg::result_t              skid_reg;
    trlp_pkg::result_t              res;

    logic signed [trlp_pkg::XW-1:0] cx;
    logic signed [trlp_pkg::XW-1:0] sy;
    logic signed [64:0]             rx;
    logic signed [64:0]             ry;
    logic signed [64:0]             mvx;
    logic signed [64:0]             mvy;

    // The whole pipeline halts only while the skid register holds a request.
    assign adv = !skid_full_reg;

    assign cx = d.side.flip ? -d.x : d.x;
    assign sy = d.side.flip ? -d.y : d.y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg   <= d.vld;
            c_reg        <= cx[31:0];
            s_reg        <= sy[31:0];
            m1_px_reg    <= d.side.px;
            m1_py_reg    <= d.side.py;
            m1_head_reg  <= d.side.head;
            m1_steer_reg <= d.side.steer;
            m1_len_reg   <= d.side.len;

            m2_vld_reg   <= m1_vld_reg;
            prod_x_reg   <= c_reg * $signed({1'b0, m1_len_reg});
            prod_y_reg   <= s_reg * $signed({1'b0, m1_len_reg});
            m2_px_reg    <= m1_px_reg;
            m2_py_reg    <= m1_py_reg;
            m2_head_reg  <= m1_head_reg;
            m2_steer_reg <= m1_steer_reg;
        end
    end

    assign rx = prod_x_reg + 65'sh20000000;
    assign ry = prod_y_reg + 65'sh20000000;
    assign mvx = rx >>> 30;
    assign mvy = ry >>> 30;

    always_comb
    begin
        res.new_x       = m2_px_reg + mvx[31:0];
        res.new_y       = m2_py_reg + mvy[31:0];
        res.new_heading = m2_head_reg;
        res.steered     = m2_steer_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (out_vld_reg && !out.ready)
        begin
            if (adv && m2_vld_reg)
            begin
                skid_reg      <= res;
                skid_full_reg <= 1'b1;
            end
        end
        else if (skid_full_reg)
        begin
            out_reg       <= skid_reg;
            out_vld_reg   <= 1'b1;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_reg     <= res;
            out_vld_reg <= m2_vld_reg;
        end
    end

    assign out.valid       = out_vld_reg;
    assign out.new_x       = out_reg.new_x;
    assign out.new_y       = out_reg.new_y;
    assign out.new_heading = out_reg.new_heading;
    assign out.steered     = out_reg.steered;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_vld_reg)
        else $error("skid register holds a request while the output is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_full_reg && out.ready) |=> (!skid_full_reg && out_vld_reg))
        else $error("skid register did not move to the output");

    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out.ready && m2_vld_reg && !skid_full_reg) |=> skid_full_reg)
        else $error("request leaving the pipeline was not kept while output stalled");
`endif

endmodule

// ----- tb/tb_turn_rate_limited_pursuit.sv -----
`timescale 1ns / 1ps

module tb_turn_rate_limited_pursuit;

    localparam int LATENCY = 38;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [31:0] ATAN [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic               target_valid;
        logic [15:0]        step_time;
    } tick_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    trlp_in_if  in_ch();
    trlp_out_if out_ch();

    turn_rate_limited_pursuit uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in(in_ch.sink),
        .out(out_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [19:0] turn_rate_q;
    logic [31:0] speed_q;
    logic [31:0] near_q;

    tick_t             tick_queue[$];
    trlp_pkg::result_t motion_queue[$];
    int                errors;
    int                idle_cycles;
    int                in_wait;
    int                out_wait;
    bit                in_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] target_bearing(longint x, longint y);
        logic [31:0] ang;
        longint xs;
        longint ys;
        ang = 32'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = 32'h80000000;
        end
        for (int i = 0; i < trlp_pkg::CORDIC_STEPS; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                ang += ATAN[i];
            end
            else
            begin
                x -= ys;
                y += xs;
                ang -= ATAN[i];
            end
        end
        ang = ang + 32'h8000;
        return ang[31:16];
    endfunction

    task automatic heading_vector(input logic [15:0] a, output longint c,
                                  output longint s);
        logic flip;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (a >= 16'd16384 && a < 16'd49152)
        begin
            a = a ^ 16'h8000;
            flip = 1'b1;
        end
        z = longint'($signed(a)) * 65536;
        for (int i = 0; i < trlp_pkg::CORDIC_STEPS; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= longint'(ATAN[i]);
            end
            else
            begin
                x += ys;
                y -= xs;
                z += longint'(ATAN[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_motion(input tick_t t);
        trlp_pkg::result_t r;
        longint dx;
        longint dy;
        longint ax;
        longint ay;
        logic [15:0] head;
        logic [127:0] dist2;
        logic [127:0] lim2;
        longint maxt;
        longint err;
        longint turn;
        longint c;
        longint s;
        longint len;
        longint mx;
        longint my;
        head = t.heading;
        r.steered = 1'b0;
        if (t.target_valid)
        begin
            dx = longint'(t.target_x) - longint'(t.pos_x);
            dy = longint'(t.target_y) - longint'(t.pos_y);
            // Squares of 33-bit differences overflow 64 bits, so square the magnitudes wide.
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            dist2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
            lim2 = 128'(near_q) * 128'(near_q);
            if (dist2 > lim2)
            begin
                maxt = (longint'(turn_rate_q) * t.step_time + 32768) >>> 16;
                err = longint'($signed(16'(target_bearing(dx, dy) - head)));
                if (err > 0)
                    turn = (err < maxt) ? err : maxt;
                else
                    turn = (err > -maxt) ? err : -maxt;
                head = 16'(longint'(head) + turn + 65536);
                r.steered = 1'b1;
            end
        end
        heading_vector(head, c, s);
        len = (longint'(speed_q) * t.step_time + 32768) >>> 16;
        mx = (len * c + (longint'(1) <<< 29)) >>> 30;
        my = (len * s + (longint'(1) <<< 29)) >>> 30;
        r.new_x = 32'(longint'(t.pos_x) + mx);
        r.new_y = 32'(longint'(t.pos_y) + my);
        r.new_heading = head;
        motion_queue.push_back(r);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Driver: one request from the queue, with a random gap before each.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken || !in_ch.valid)
            begin
                if (in_taken)
                    in_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
                if (in_wait > 0)
                begin
                    in_ch.valid <= 1'b0;
                    in_wait = in_wait - 1;
                end
                else if (tick_queue.size() > 0)
                begin
                    {in_ch.pos_x, in_ch.pos_y, in_ch.heading, in_ch.target_x,
                     in_ch.target_y, in_ch.target_valid, in_ch.step_time}
                        <= tick_queue.pop_front();
                    in_ch.valid <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
            out_ch.ready <= (out_wait == 0);
        end
    end

    // Acceptance and checking at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_ch.valid && in_ch.ready)
            begin
                predict_motion({in_ch.pos_x, in_ch.pos_y, in_ch.heading, in_ch.target_x,
                                in_ch.target_y, in_ch.target_valid, in_ch.step_time});
            end
            if (out_ch.valid && out_ch.ready)
            begin
                trlp_pkg::result_t want;
                out_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
                if (motion_queue.size() == 0)
                    report("unexpected result", out_ch.new_x, 0);
                else
                begin
                    want = motion_queue.pop_front();
                    if (out_ch.new_x !== want.new_x)
                        report("new_x", out_ch.new_x, want.new_x);
                    if (out_ch.new_y !== want.new_y)
                        report("new_y", out_ch.new_y, want.new_y);
                    if (out_ch.new_heading !== want.new_heading)
                        report("new_heading", out_ch.new_heading, want.new_heading);
                    if (out_ch.steered !== want.steered)
                        report("steered", out_ch.steered, want.steered);
                end
            end
            else if (out_wait > 0)
                out_wait = out_wait - 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input trlp_pkg::cfg_reg_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            trlp_pkg::REG_TURN_RATE:  turn_rate_q = val[19:0];
            trlp_pkg::REG_MOVE_SPEED: speed_q = val;
            default:                  near_q = val;
        endcase
    endtask

    task automatic drain();
        while (tick_queue.size() > 0 || in_ch.valid || motion_queue.size() > 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic tick_t rand_tick();
        tick_t t;
        logic signed [31:0] off;
        t.pos_x = $urandom;
        t.pos_y = $urandom;
        t.heading = $urandom;
        t.target_valid = ($urandom_range(0, 5) != 0);
        t.step_time = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
        case ($urandom_range(0, 3))
            0:
            begin
                t.target_x = $urandom;
                t.target_y = $urandom;
            end
            1:
            begin
                // Near the mover, straddling the near distance.
                off = $signed(32'($urandom_range(0, 65536))) - 32768;
                t.target_x = t.pos_x + off;
                off = $signed(32'($urandom_range(0, 65536))) - 32768;
                t.target_y = t.pos_y + off;
            end
            default:
            begin
                off = $signed($urandom) >>> $urandom_range(4, 20);
                t.target_x = t.pos_x + off;
                off = $signed($urandom) >>> $urandom_range(4, 20);
                t.target_y = t.pos_y + off;
            end
        endcase
        return t;
    endfunction

    function automatic tick_t make_tick(int px, int py, int h, int tx, int ty, bit v, int dt);
        tick_t t;
        t.pos_x = px;
        t.pos_y = py;
        t.heading = h;
        t.target_x = tx;
        t.target_y = ty;
        t.target_valid = v;
        t.step_time = dt;
        return t;
    endfunction

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        in_wait = 0;
        out_wait = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = trlp_pkg::REG_TURN_RATE;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.heading = '0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        in_ch.target_valid = 1'b0;
        in_ch.step_time = '0;
        out_ch.ready = 1'b0;
        turn_rate_q = 20'd31291;
        speed_q = 32'd0;
        near_q = 32'd32768;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Defaults first: speed is zero, so only heading changes.
        tick_queue.push_back(make_tick(0, 0, 0, 65536, 65536, 1, 65535));
        tick_queue.push_back(make_tick(0, 0, 100, 10, 10, 1, 65535));
        drain();

        write_reg(trlp_pkg::REG_MOVE_SPEED, 32'h0003_0000);
        write_reg(trlp_pkg::REG_NEAR_LIMIT, 32'h0001_0000);
        // Invalid target, near target, exact near distance, zero step time,
        // half turn behind, huge turn, extremes of position that wrap.
        tick_queue.push_back(make_tick(0, 0, 0, 100 << 16, 0, 0, 32768));
        tick_queue.push_back(make_tick(0, 0, 16384, 100, 100, 1, 32768));
        tick_queue.push_back(make_tick(0, 0, 0, 65536, 0, 1, 32768));
        tick_queue.push_back(make_tick(0, 0, 0, 65537, 0, 1, 32768));
        tick_queue.push_back(make_tick(0, 0, 0, 0, 5 << 16, 1, 0));
        tick_queue.push_back(make_tick(0, 0, 0, -(5 << 16), 0, 1, 65535));
        tick_queue.push_back(make_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 8192,
                                       32'h8000_0000, 32'h8000_0000, 1, 65535));
        tick_queue.push_back(make_tick(32'h8000_0000, 32'h8000_0000, 40000,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 65535));
        tick_queue.push_back(make_tick(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 65535));
        tick_queue.push_back(make_tick(0, 0, 65535, -1, -1, 1, 1));
        drain();

        write_reg(trlp_pkg::REG_TURN_RATE, 32'h000F_FFFF);
        write_reg(trlp_pkg::REG_MOVE_SPEED, 32'hFFFF_FFFF);
        write_reg(trlp_pkg::REG_NEAR_LIMIT, 32'd0);
        tick_queue.push_back(make_tick(0, 0, 0, 0, 1, 1, 65535));
        tick_queue.push_back(make_tick(0, 0, 0, 0, 0, 1, 65535));
        tick_queue.push_back(make_tick(0, 0, 49152, -1, 0, 1, 65535));
        tick_queue.push_back(make_tick(0, 0, 32768, 10, 0, 1, 12345));
        drain();

        write_reg(trlp_pkg::REG_TURN_RATE, 32'd0);
        write_reg(trlp_pkg::REG_NEAR_LIMIT, 32'hFFFF_FFFF);
        tick_queue.push_back(make_tick(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 1, 65535));
        tick_queue.push_back(make_tick(0, 0, 30000, 3 << 16, 0, 1, 65535));
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(trlp_pkg::REG_TURN_RATE,
                      $urandom_range(0, 3) == 0 ? 32'($urandom)
                                                : $urandom_range(0, 200000));
            write_reg(trlp_pkg::REG_MOVE_SPEED,
                      $urandom_range(0, 3) == 0 ? $urandom
                                                : $urandom_range(0, 1 << 24));
            write_reg(trlp_pkg::REG_NEAR_LIMIT,
                      $urandom_range(0, 4) == 0 ? $urandom
                                                : $urandom_range(0, 1 << 17));
            for (int k = 0; k < 100; k++)
                tick_queue.push_back(rand_tick());
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
